// File: sv/client_id_registry_table_top_assert.svh
// Assertion macros used by the checker of the client id registry table.
// Every property is sampled on i_clk and is off while i_rst_n is low.
`ifndef CLIENT_ID_REGISTRY_TABLE_TOP_ASSERT_SVH
`define CLIENT_ID_REGISTRY_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CIDRT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CIDRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/cidrt_pkg.sv
`timescale 1ns / 1ps

package cidrt_pkg;

    localparam int ID_W     = 32;
    localparam int NAME_W   = 16;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_UPSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd5;

    // Per-cycle commands broadcast to every cell of the chain.
    typedef struct packed {
        logic capture;   // compare stored id against the incoming key
        logic update;    // first matching cell takes the new handle
        logic insert;    // cell at the tail takes the new id and handle
        logic remove;    // matching cell and all later cells take the neighbor's entry
    } t_cell_ctl;

endpackage

// File: sv/cidrt_cell.sv
`timescale 1ns / 1ps

module cidrt_cell #(
    parameter int CW       = 5,
    parameter int SLOT_IDX = 0
) (
    input  logic                      i_clk,
    input  cidrt_pkg::t_cell_ctl      i_ctl,
    input  logic [CW-1:0]             i_count,
    input  logic [cidrt_pkg::ID_W-1:0]   i_probe_key,
    input  logic [cidrt_pkg::ID_W-1:0]   i_key,
    input  logic [cidrt_pkg::NAME_W-1:0] i_name,
    input  logic [cidrt_pkg::ID_W-1:0]   i_next_id,
    input  logic [cidrt_pkg::NAME_W-1:0] i_next_name,
    input  logic                      i_seen,
    output logic                      o_seen,
    output logic                      o_first,
    output logic [cidrt_pkg::ID_W-1:0]   o_id,
    output logic [cidrt_pkg::NAME_W-1:0] o_name
);
    import cidrt_pkg::*;

    localparam logic [CW-1:0] LIDX = CW'(SLOT_IDX);

    logic [ID_W-1:0]   r_id;
    logic [NAME_W-1:0] r_name;
    logic              r_match;
    logic              w_live;

    assign w_live  = (LIDX < i_count);
    // A match is the first one in the chain when no earlier cell matched.
    assign o_first = r_match & ~i_seen;
    assign o_seen  = r_match | i_seen;
    assign o_id    = r_id;
    assign o_name  = r_name;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_match <= w_live && (r_id == i_probe_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.remove && o_seen) begin
            r_id   <= i_next_id;
            r_name <= i_next_name;
        end else if (i_ctl.insert && (LIDX == i_count)) begin
            r_id   <= i_key;
            r_name <= i_name;
        end else if (i_ctl.update && o_first) begin
            r_name <= i_name;
        end
    end

endmodule

// File: sv/client_id_registry_table_top.sv
`timescale 1ns / 1ps

// Client id registry: a table of connection ids with name handles, packed from slot zero.
// The input channel (i_in_valid / o_in_ready) carries one command per transfer:
// upsert, remove or lookup, with the id to match and, for upsert, the new handle.
// The output channel (o_out_valid / i_out_ready) returns exactly one result per
// command: status, slot, whether the id was present, its previous handle and the
// number of live entries after the command.
// When a command is accepted, every cell registers the compare of its id with the key.
// Once the output register is free, the cells resolve the first match, update or
// shift, and the result is loaded into the output register.
// The block takes a new command only after the pending one has executed; the
// compare and the update of the cell chain are separate register steps.
// If the receiver stalls, the result waits in the output register and the
// pending command waits in the chain until the register is free; o_in_ready
// stays low while a command is pending.
// Reset clears the entry count and the handshake state; the cells need no
// clearing since only slots below the entry count are ever matched or read.

module client_id_registry_table_top #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [cidrt_pkg::CMD_W-1:0]         i_cmd,
    input  logic [cidrt_pkg::ID_W-1:0]          i_client_id,
    input  logic [cidrt_pkg::NAME_W-1:0]        i_name_ref,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [cidrt_pkg::STATUS_W-1:0]      o_status,
    output logic [cidrt_pkg::SLOT_W-1:0]        o_slot,
    output logic                                o_had_entry,
    output logic [cidrt_pkg::NAME_W-1:0]        o_prev_name_ref,
    output logic [cidrt_pkg::COUNT_W-1:0]       o_entry_count
);
    import cidrt_pkg::*;

    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int IW = $clog2(TABLE_SLOTS);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_SLOTS);

    // Pending command, captured at acceptance, and the entry count.
    logic              r_busy;
    logic [CMD_W-1:0]  r_cmd;
    logic [ID_W-1:0]   r_key;
    logic [NAME_W-1:0] r_name;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;

    // Output register.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_had;
    logic [NAME_W-1:0]   r_prev;
    logic [COUNT_W-1:0]  r_ecount;

    logic w_accept;
    logic w_exec;
    logic w_hit;
    logic w_full;
    logic w_insert;
    t_cell_ctl w_ctl;

    logic [ID_W-1:0]   w_id   [TABLE_SLOTS];
    logic [NAME_W-1:0] w_name [TABLE_SLOTS];
    logic [TABLE_SLOTS:0]   w_seen;
    logic [TABLE_SLOTS-1:0] w_first;

    logic [IW-1:0]      w_hit_slot;
    logic [NAME_W-1:0]  w_hit_name;
    logic [IW-1:0]      w_slot;
    logic [IW+SLOT_W-1:0]  w_slot_ext;
    logic [CW+COUNT_W-1:0] w_count_ext;

    assign w_accept = i_in_valid && !r_busy;
    // The pending command executes once the output register can take its result.
    assign w_exec   = r_busy && (!r_out_valid || i_out_ready);
    assign w_hit    = w_seen[TABLE_SLOTS];
    assign w_full   = (r_count == FULL_COUNT);
    assign w_insert = (r_cmd == CMD_UPSERT) && !w_hit && !w_full;

    assign w_ctl.capture = w_accept;
    assign w_ctl.update  = w_exec && (r_cmd == CMD_UPSERT) && w_hit;
    assign w_ctl.insert  = w_exec && w_insert;
    assign w_ctl.remove  = w_exec && (r_cmd == CMD_REMOVE) && w_hit;

    assign w_seen[0] = 1'b0;

    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        logic [ID_W-1:0]   w_next_id;
        logic [NAME_W-1:0] w_next_name;

        if (g == TABLE_SLOTS - 1) begin : g_tail
            // The last cell shifts in zeros; its content is dead after a removal.
            assign w_next_id   = '0;
            assign w_next_name = '0;
        end else begin : g_link
            assign w_next_id   = w_id[g+1];
            assign w_next_name = w_name[g+1];
        end

        cidrt_cell #(
            .CW       (CW),
            .SLOT_IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_probe_key (i_client_id),
            .i_key       (r_key),
            .i_name      (r_name),
            .i_next_id   (w_next_id),
            .i_next_name (w_next_name),
            .i_seen      (w_seen[g]),
            .o_seen      (w_seen[g+1]),
            .o_first     (w_first[g]),
            .o_id        (w_id[g]),
            .o_name      (w_name[g])
        );
    end

    // At most one cell reports the first match, so the slot and handle are an OR.
    always_comb begin
        w_hit_slot = '0;
        w_hit_name = '0;
        for (int k = 0; k < TABLE_SLOTS; k++) begin
            if (w_first[k]) begin
                w_hit_slot = w_hit_slot | IW'(k);
                w_hit_name = w_hit_name | w_name[k];
            end
        end
    end

    always_comb begin
        if (w_hit) begin
            w_slot = w_hit_slot;
        end else if (w_insert) begin
            w_slot = IW'(r_count);
        end else begin
            w_slot = '0;
        end
    end

    always_comb begin
        n_count = r_count;
        case (r_cmd)
            CMD_UPSERT: begin
                if (w_hit) begin
                    n_status = ST_UPDATED;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_INSERTED;
                    n_count  = r_count + CW'(1);
                end
            end
            CMD_REMOVE: begin
                if (w_hit) begin
                    n_status = ST_REMOVED;
                    n_count  = r_count - CW'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                // Lookup, and the unused code behaves the same way.
                n_status = w_hit ? ST_FOUND : ST_NOT_FOUND;
            end
        endcase
    end

    assign w_slot_ext  = {{SLOT_W{1'b0}}, w_slot};
    assign w_count_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end

            if (w_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_cmd;
            r_key  <= i_client_id;
            r_name <= i_name_ref;
        end
        if (w_exec) begin
            r_status <= n_status;
            r_slot   <= w_slot_ext[SLOT_W-1:0];
            r_had    <= w_hit;
            r_prev   <= w_hit_name;
            r_ecount <= w_count_ext[COUNT_W-1:0];
        end
    end

    assign o_in_ready      = !r_busy;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_slot          = r_slot;
    assign o_had_entry     = r_had;
    assign o_prev_name_ref = r_prev;
    assign o_entry_count   = r_ecount;

endmodule

// File: sv/cidrt_checker.sv
`timescale 1ns / 1ps
`include "client_id_registry_table_top_assert.svh"

module cidrt_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic [cidrt_pkg::STATUS_W-1:0] o_status,
    input  logic [cidrt_pkg::SLOT_W-1:0]   o_slot,
    input  logic                           o_had_entry,
    input  logic [cidrt_pkg::NAME_W-1:0]   o_prev_name_ref
);
    import cidrt_pkg::*;

    // A stalled result keeps its value.
    `CIDRT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_slot), "result changed while stalled")

    // One command is in flight at a time.
    `CIDRT_ASSERT_NEXT(a_one_pending, i_in_valid && o_in_ready, !o_in_ready, "second transfer taken while a command is pending")

    // A miss or a full drop carries no slot and no previous handle.
    `CIDRT_ASSERT_SAME(a_miss_clean, o_out_valid && (o_status == ST_NOT_FOUND || o_status == ST_FULL), !o_had_entry && o_slot == '0 && o_prev_name_ref == '0, "miss result carries entry data")

    // Presence flag agrees with the status code.
    `CIDRT_ASSERT_SAME(a_had_status, o_out_valid, o_had_entry == (o_status == ST_UPDATED || o_status == ST_REMOVED || o_status == ST_FOUND), "presence flag disagrees with status")

endmodule

bind client_id_registry_table_top cidrt_checker u_cidrt_checker (.*);

// File: tb/client_id_registry_table_top_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the client id registry table.
// A queue of pending commands, filled by the stimulus process, feeds a clocked
// driver on the input channel. A clocked monitor watches both channels: each
// input transfer runs through a software copy of the table, which yields the
// expected reply, and each output transfer is checked against the oldest one.

module client_id_registry_table_top_tb;

    import cidrt_pkg::*;

    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 60000;
    localparam int RAND_CMDS   = 850;
    localparam int POOL_SIZE   = 20;

    // Command code three is not used by the protocol, but the block treats it as a lookup.
    localparam logic [CMD_W-1:0] CMD_ALIAS = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   id;
        logic [NAME_W-1:0] name;
        bit                hold;    // wait for every outstanding reply before sending
    } t_cmd_req;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                had;
        logic [NAME_W-1:0]   prev;
        logic [COUNT_W-1:0]  count;
    } t_reply;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic [CMD_W-1:0]    i_cmd = '0;
    logic [ID_W-1:0]     i_client_id = '0;
    logic [NAME_W-1:0]   i_name_ref = '0;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot;
    logic                o_had_entry;
    logic [NAME_W-1:0]   o_prev_name_ref;
    logic [COUNT_W-1:0]  o_entry_count;

    client_id_registry_table_top #(
        .TABLE_SLOTS(SLOTS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_client_id    (i_client_id),
        .i_name_ref     (i_name_ref),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_had_entry    (o_had_entry),
        .o_prev_name_ref(o_prev_name_ref),
        .o_entry_count  (o_entry_count)
    );

    // 20 ns clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Software copy of the table. Only slots below tbl_count are ever read,
    // matching the block, whose cells are never cleared.
    logic [ID_W-1:0]   tbl_ids   [SLOTS];
    logic [NAME_W-1:0] tbl_names [SLOTS];
    int                tbl_count = 0;

    t_cmd_req pending_cmds[$];
    t_reply   expected_replies[$];

    int n_accepted = 0;     // input transfers, owned by the driver
    int n_checked  = 0;     // replies matched to an expectation, owned by the monitor
    int n_errors   = 0;
    int gap_left   = 0;
    int cycle_count = 0;
    int status_seen [6];
    t_cmd_req nxt_cmd;
    t_reply   want;

    // Apply one command to the software table and return the reply it implies.
    // The lowest matching slot wins; remove closes the hole by shifting the tail down.
    function automatic t_reply registry_apply(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                              logic [NAME_W-1:0] name);
        t_reply r;
        int     hit;
        hit = -1;
        for (int i = 0; i < tbl_count; i++) begin
            if (hit < 0 && tbl_ids[i] == id) hit = i;
        end
        r.status = ST_NOT_FOUND;
        r.slot   = '0;
        r.had    = 1'b0;
        r.prev   = '0;
        if (hit >= 0) begin
            r.had  = 1'b1;
            r.slot = hit[SLOT_W-1:0];
            r.prev = tbl_names[hit];
        end
        case (cmd)
            CMD_UPSERT: begin
                if (hit >= 0) begin
                    tbl_names[hit] = name;
                    r.status = ST_UPDATED;
                end else if (tbl_count >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_ids[tbl_count]   = id;
                    tbl_names[tbl_count] = name;
                    r.slot    = tbl_count[SLOT_W-1:0];
                    tbl_count = tbl_count + 1;
                    r.status  = ST_INSERTED;
                end
            end
            CMD_REMOVE: begin
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < tbl_count; i++) begin
                        tbl_ids[i]   = tbl_ids[i + 1];
                        tbl_names[i] = tbl_names[i + 1];
                    end
                    tbl_count = tbl_count - 1;
                    r.status  = ST_REMOVED;
                end
            end
            default: begin
                if (hit >= 0) r.status = ST_FOUND;
            end
        endcase
        r.count = tbl_count[COUNT_W-1:0];
        return r;
    endfunction

    task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                             logic [NAME_W-1:0] name, bit hold);
        t_cmd_req c;
        c.cmd  = cmd;
        c.id   = id;
        c.name = name;
        c.hold = hold;
        pending_cmds.push_back(c);
    endtask

    // Driver. A new command is presented only once the previous transfer has
    // happened, so valid and the payload stay put while the block is busy.
    // Commands 350 to 549 go out back to back, with no random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) n_accepted++;
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_cmds.size() == 0 ||
                             (pending_cmds[0].hold && n_accepted != n_checked)) begin
                    i_in_valid <= 1'b0;
                end else if (!(n_accepted >= 350 && n_accepted < 550) &&
                             $urandom_range(99) < 8) begin
                    gap_left = $urandom_range(2, 0);
                    i_in_valid <= 1'b0;
                end else begin
                    nxt_cmd = pending_cmds.pop_front();
                    i_cmd       <= nxt_cmd.cmd;
                    i_client_id <= nxt_cmd.id;
                    i_name_ref  <= nxt_cmd.name;
                    i_in_valid  <= 1'b1;
                end
            end
        end
    end

    // Monitor. Input transfers are predicted first, then an output transfer is
    // checked, so the outcome never depends on the order of processes at an edge.
    // The receiver stalls at random with a chance of 8 in 100, except while replies 350 to 549 arrive.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                expected_replies.push_back(registry_apply(i_cmd, i_client_id, i_name_ref));
            if (o_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    $error("reply with no command outstanding: status %0d slot %0d",
                           o_status, o_slot);
                    n_errors++;
                end else begin
                    want = expected_replies.pop_front();
                    n_checked++;
                    if (want.status < 6) status_seen[want.status]++;
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        n_errors++;
                    end
                    if (o_slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, o_slot);
                        n_errors++;
                    end
                    if (o_had_entry !== want.had) begin
                        $error("had_entry: expected %0d, got %0d", want.had, o_had_entry);
                        n_errors++;
                    end
                    if (o_prev_name_ref !== want.prev) begin
                        $error("prev_name_ref: expected 0x%04h, got 0x%04h",
                               want.prev, o_prev_name_ref);
                        n_errors++;
                    end
                    if (o_entry_count !== want.count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.count, o_entry_count);
                        n_errors++;
                    end
                end
            end
        end
        if (n_checked >= 350 && n_checked < 550)
            i_out_ready <= 1'b1;
        else
            i_out_ready <= ($urandom_range(99) >= 8);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("client_id_registry_table_top regression: fail");
            $finish;
        end
    end

    initial begin
        logic [ID_W-1:0]  id_pool [POOL_SIZE];
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  id;
        int               up_pct;
        int               rm_pct;
        int               roll;

        // Directed part: empty-table misses, the extreme ids and handles, the
        // alias of lookup, an update in place, filling the table, a new id on a
        // full table, an update on a full table, and removes at the middle,
        // the tail and the head.
        queue_cmd(CMD_LOOKUP, 32'h0000_0000, 16'h0000, 1'b0);
        queue_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        queue_cmd(CMD_UPSERT, 32'h0000_0000, 16'h0000, 1'b0);
        queue_cmd(CMD_UPSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        queue_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1'b0);
        queue_cmd(CMD_ALIAS,  32'h0000_0000, 16'h5A5A, 1'b0);
        queue_cmd(CMD_UPSERT, 32'h0000_0000, 16'hA5A5, 1'b0);
        for (int i = 1; i <= SLOTS - 2; i++)
            queue_cmd(CMD_UPSERT, 32'h1111_1111 * i + 32'd7, 16'(i * 16'h0101), 1'b0);
        queue_cmd(CMD_UPSERT, 32'hDEAD_0001, 16'h7777, 1'b0);
        queue_cmd(CMD_UPSERT, 32'hFFFF_FFFF, 16'h1234, 1'b0);
        queue_cmd(CMD_REMOVE, 32'h1111_1111 * 4 + 32'd7, 16'h0000, 1'b0);
        queue_cmd(CMD_LOOKUP, 32'h1111_1111 * 5 + 32'd7, 16'h0000, 1'b0);
        queue_cmd(CMD_REMOVE, 32'h1111_1111 * 14 + 32'd7, 16'h0000, 1'b0);
        queue_cmd(CMD_REMOVE, 32'h0000_0000, 16'h0000, 1'b0);
        queue_cmd(CMD_LOOKUP, 32'h0000_0000, 16'h0000, 1'b0);

        // Random part: ids mostly come from a pool slightly larger than the
        // table, so hits, fills and overflows are common. The mix of upserts
        // and removes moves through five phases to fill, churn and drain it.
        for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom();
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int n = 0; n < RAND_CMDS; n++) begin
            case (n / 170)
                0:       begin up_pct = 70; rm_pct = 15; end
                1:       begin up_pct = 45; rm_pct = 30; end
                2:       begin up_pct = 15; rm_pct = 60; end
                3:       begin up_pct = 60; rm_pct = 20; end
                default: begin up_pct = 35; rm_pct = 30; end
            endcase
            roll = $urandom_range(99);
            if (roll < up_pct)               cmd = CMD_UPSERT;
            else if (roll < up_pct + rm_pct) cmd = CMD_REMOVE;
            else if (roll < 95)              cmd = CMD_LOOKUP;
            else                             cmd = CMD_ALIAS;
            if ($urandom_range(9) == 0) id = $urandom();
            else                        id = id_pool[$urandom_range(POOL_SIZE - 1)];
            // The first random command and one mid-run wait for the block to empty.
            queue_cmd(cmd, id, 16'($urandom()), n == 0 || n == 600);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || i_in_valid || n_checked != n_accepted)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (expected_replies.size() != 0) begin
            $error("%0d replies never arrived", expected_replies.size());
            n_errors++;
        end

        $display("Sent %0d commands and checked %0d replies over %0d cycles.",
                 n_accepted, n_checked, cycle_count);
        $display("Replies by kind: updated %0d, inserted %0d, full %0d, removed %0d, %s",
                 status_seen[ST_UPDATED], status_seen[ST_INSERTED], status_seen[ST_FULL],
                 status_seen[ST_REMOVED],
                 $sformatf("not found %0d, found %0d.",
                           status_seen[ST_NOT_FOUND], status_seen[ST_FOUND]));
        if (n_errors == 0)
            $display("client_id_registry_table_top regression: pass");
        else
            $display("client_id_registry_table_top regression: fail");
        $finish;
    end

endmodule
